/* design/lsepa_pkg.sv */
package lsepa_pkg;

    localparam int LOGIT_W = 24;
    localparam int TGT_W   = 18;
    localparam int LEN_W   = 19;
    localparam int SUM_W   = 40;
    localparam int LP_W    = 25;
    localparam int LL_W    = 48;
    localparam int SQ_W    = 63;
    localparam int CNT_W   = 32;
    localparam int EXP_W   = 23;

    localparam logic [LEN_W-1:0] LEN_RESET = 19'd32768;
    localparam logic [LEN_W-1:0] LEN_MAX   = 19'd262144;
    localparam logic [SUM_W-1:0] SUM_ONE   = 40'd4194304;
    localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};
    localparam logic [30:0] L2E_Q30 = 31'd1549082005;
    localparam logic [29:0] LN2_Q30 = 30'd744261118;

    // datapath commands
    localparam logic [3:0] OP_NONE  = 4'd0;
    localparam logic [3:0] OP_LOAD  = 4'd1; // capture input, distance to max
    localparam logic [3:0] OP_EXP   = 4'd2; // scale distance to a power-of-two index
    localparam logic [3:0] OP_EXPV  = 4'd8; // exponent table interpolation and shift
    localparam logic [3:0] OP_ACC   = 4'd3; // update running sum
    localparam logic [3:0] OP_LOG   = 4'd4; // log stage 1
    localparam logic [3:0] OP_LN    = 4'd5; // log stage 2
    localparam logic [3:0] OP_TOT   = 4'd6; // square and totals
    localparam logic [3:0] OP_TOT2  = 4'd7; // saturate and publish

    typedef struct packed {
        logic [3:0] op;
    } dp_cmd_t;

    typedef struct packed {
        logic row_end;
    } dp_stat_t;

    function automatic logic [22:0] exp2_lut(input logic [4:0] k);
        logic [22:0] v;
        case (k)
            5'd0: v = 23'd4194304;  5'd1: v = 23'd4016479;
            5'd2: v = 23'd3846194;  5'd3: v = 23'd3683128;
            5'd4: v = 23'd3526975;  5'd5: v = 23'd3377443;
            5'd6: v = 23'd3234250;  5'd7: v = 23'd3097129;
            5'd8: v = 23'd2965821;  5'd9: v = 23'd2840080;
            5'd10: v = 23'd2719670; 5'd11: v = 23'd2604365;
            5'd12: v = 23'd2493948; 5'd13: v = 23'd2388213;
            5'd14: v = 23'd2286960; 5'd15: v = 23'd2190001;
            default: v = 23'd2097152;
        endcase
        return v;
    endfunction

    function automatic logic [16:0] log2_lut(input logic [4:0] k);
        logic [16:0] v;
        case (k)
            5'd0: v = 17'd0;      5'd1: v = 17'd5732;
            5'd2: v = 17'd11136;  5'd3: v = 17'd16248;
            5'd4: v = 17'd21098;  5'd5: v = 17'd25711;
            5'd6: v = 17'd30109;  5'd7: v = 17'd34312;
            5'd8: v = 17'd38336;  5'd9: v = 17'd42196;
            5'd10: v = 17'd45904; 5'd11: v = 17'd49472;
            5'd12: v = 17'd52911; 5'd13: v = 17'd56229;
            5'd14: v = 17'd59434; 5'd15: v = 17'd62534;
            default: v = 17'd65536;
        endcase
        return v;
    endfunction

endpackage

/* design/lsepa_ctrl.sv */
module lsepa_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  lsepa_pkg::dp_stat_t stat,
    output lsepa_pkg::dp_cmd_t  cmd,
    output logic               cfg_ready
);
    import lsepa_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXP  = 3'd1;
    localparam logic [2:0] ST_ACC  = 3'd2;
    localparam logic [2:0] ST_LOG  = 3'd3;
    localparam logic [2:0] ST_LN   = 3'd4;
    localparam logic [2:0] ST_TOT  = 3'd5;
    localparam logic [2:0] ST_TOT2 = 3'd6;
    localparam logic [2:0] ST_EXPV = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       mv_reg, mv_next;

    // a result stays in the output register; only the publish step waits for it
    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = mv_reg;
    // a write never lands on the edge that takes a logit
    assign cfg_ready = (state_reg == ST_IDLE) && !s_valid;

    always_comb begin
        state_next = state_reg;
        mv_next    = mv_reg && !m_ready;
        cmd.op     = OP_NONE;
        unique case (state_reg)
            ST_IDLE: if (s_valid) begin
                cmd.op = OP_LOAD;
                state_next = ST_EXP;
            end
            ST_EXP: begin
                cmd.op = OP_EXP;
                state_next = ST_EXPV;
            end
            ST_EXPV: begin
                cmd.op = OP_EXPV;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                cmd.op = OP_ACC;
                state_next = stat.row_end ? ST_LOG : ST_IDLE;
            end
            ST_LOG: begin
                cmd.op = OP_LOG;
                state_next = ST_LN;
            end
            ST_LN: begin
                cmd.op = OP_LN;
                state_next = ST_TOT;
            end
            ST_TOT: begin
                cmd.op = OP_TOT;
                state_next = ST_TOT2;
            end
            ST_TOT2: if (!mv_next) begin
                cmd.op = OP_TOT2;
                mv_next = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
        end
    end
endmodule

/* design/lsepa_datapath.sv */
module lsepa_datapath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  lsepa_pkg::dp_cmd_t          cmd,
    output lsepa_pkg::dp_stat_t         stat,
    input  logic                        cfg_we,
    input  logic [lsepa_pkg::LEN_W-1:0] cfg_data,
    input  logic signed [lsepa_pkg::LOGIT_W-1:0] s_logit,
    input  logic [lsepa_pkg::TGT_W-1:0] s_target_token,
    input  logic                        s_clear_totals,
    output logic signed [lsepa_pkg::LP_W-1:0] m_row_log_prob,
    output logic signed [lsepa_pkg::LL_W-1:0] m_total_log_lik,
    output logic [lsepa_pkg::SQ_W-1:0]  m_total_log_lik_sq,
    output logic [lsepa_pkg::CNT_W-1:0] m_scored_count
);
    import lsepa_pkg::*;

    logic [LEN_W-1:0]          len_reg;
    logic signed [LOGIT_W-1:0] max_reg, x_reg, tgt_hold_reg;
    logic [SUM_W-1:0]          sum_reg;
    logic [TGT_W-1:0]          idx_reg;
    logic                      first_reg, newmax_reg, row_end_reg;
    logic [24:0]               d_reg;
    logic [27:0]               t_reg;
    logic [EXP_W-1:0]          e_reg;
    logic signed [LL_W-1:0]    ll_reg;
    logic [SQ_W-1:0]           sq_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic [22:0]               l2_reg;
    logic signed [LP_W-1:0]    lp_reg;
    logic [49:0]               psq_reg;
    logic signed [LL_W-1:0]    ll_new_reg;

    // effective row length
    logic [LEN_W-1:0] eff_len;
    always_comb begin
        eff_len = len_reg;
        if (eff_len < 19'd2) eff_len = 19'd2;
        if (eff_len > LEN_MAX) eff_len = LEN_MAX;
    end

    logic signed [LOGIT_W:0] diff;
    logic [55:0] dprod;
    assign diff  = {s_logit[LOGIT_W-1], s_logit} - {max_reg[LOGIT_W-1], max_reg};
    assign dprod = {31'd0, d_reg} * {25'd0, L2E_Q30};

    // exponent interpolation
    logic [4:0]  eseg;
    logic [11:0] er;
    logic [22:0] ea, eb, ev;
    logic [34:0] eprod;
    assign eseg  = {1'b0, t_reg[15:12]};
    assign er    = t_reg[11:0];
    assign ea    = exp2_lut(eseg);
    assign eb    = exp2_lut(eseg + 5'd1);
    assign eprod = {12'd0, ea - eb} * {23'd0, er} + 35'd2048;
    assign ev    = ea - eprod[34:12];

    logic [63:0] rprod;
    logic [SUM_W:0] acc_sum;
    assign rprod   = {24'd0, sum_reg} * {41'd0, e_reg};
    always_comb begin
        if (newmax_reg)
            acc_sum = 41'((rprod[SUM_W+22:0] + 63'd2097152) >> 22) + {1'b0, SUM_ONE};
        else
            acc_sum = {1'b0, sum_reg} + {18'd0, e_reg};
    end

    // log stage: leading one and mantissa
    logic [SUM_W-1:0] ls;
    logic [4:0]       lpos;
    logic [15:0]      lm;
    logic [16:0]      la, lb;
    logic [28:0]      lprod;
    always_comb begin
        ls = (sum_reg < SUM_ONE) ? SUM_ONE : sum_reg;
        lpos = 5'd0;
        for (int i = 23; i < 40; i++)
            if (ls[i]) lpos = 5'(i - 22);
        lm = 16'(ls >> (lpos + 5'd6));
        la = log2_lut({1'b0, lm[15:12]});
        lb = log2_lut({1'b0, lm[15:12]} + 5'd1);
        lprod = {12'd0, lb - la} * {17'd0, lm[11:0]} + 29'd2048;
    end

    logic [52:0] lnprod;
    logic [22:0] lnv;
    logic signed [26:0] lpw;
    assign lnprod = {30'd0, l2_reg} * {23'd0, LN2_Q30} + 53'd536870912;
    assign lnv    = lnprod[52:30];
    assign lpw    = 27'(tgt_hold_reg) - 27'(max_reg) - $signed({4'd0, lnv});

    logic [LP_W-1:0] mag;
    assign mag = LP_W'(-lp_reg);

    assign stat.row_end = row_end_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= LEN_RESET;
            max_reg <= '0; sum_reg <= '0; tgt_hold_reg <= '0; idx_reg <= '0;
            ll_reg <= '0; sq_reg <= '0; cnt_reg <= '0;
        end else begin
            if (cfg_we) len_reg <= cfg_data;
            case (cmd.op)
                OP_LOAD: begin
                    if (s_clear_totals) begin
                        ll_reg <= '0; sq_reg <= '0; cnt_reg <= '0;
                    end
                    x_reg      <= s_logit;
                    first_reg  <= (idx_reg == '0);
                    newmax_reg <= (diff > 0);
                    d_reg      <= (diff > 0) ? 25'(diff) : 25'(-diff);
                    if (s_target_token == idx_reg) tgt_hold_reg <= s_logit;
                    else if (idx_reg == '0) tgt_hold_reg <= '0;
                    row_end_reg <= ({1'b0, idx_reg} + 19'd1 >= eff_len);
                end
                OP_EXP: t_reg <= 28'((dprod + 56'd536870912) >> 30);
                OP_EXPV: e_reg <= (t_reg[27:16] > 12'd23) ? '0 : 23'(ev >> t_reg[20:16]);
                OP_ACC: begin
                    if (first_reg) begin
                        max_reg <= x_reg; sum_reg <= SUM_ONE;
                    end else begin
                        sum_reg <= acc_sum[SUM_W] ? SUM_MAX : acc_sum[SUM_W-1:0];
                        if (newmax_reg) max_reg <= x_reg;
                    end
                    idx_reg <= row_end_reg ? '0 : idx_reg + 1'b1;
                end
                OP_LOG: l2_reg <= {2'd0, lpos, 16'd0} + {6'd0, la} + {6'd0, lprod[28:12]};
                OP_LN: lp_reg <= (lpw > 0) ? '0 :
                                 (lpw < -27'sd16777216) ? -25'sd16777216 : LP_W'(lpw);
                OP_TOT: begin
                    psq_reg    <= {25'd0, mag} * {25'd0, mag};
                    ll_new_reg <= (ll_reg + LL_W'(lp_reg) > ll_reg) ?
                                  {1'b1, {(LL_W-1){1'b0}}} : ll_reg + LL_W'(lp_reg);
                end
                OP_TOT2: begin
                    ll_reg <= ll_new_reg;
                    sq_reg <= (sq_reg > {SQ_W{1'b1}} - 63'(psq_reg)) ?
                              {SQ_W{1'b1}} : sq_reg + 63'(psq_reg);
                    if (cnt_reg != {CNT_W{1'b1}}) cnt_reg <= cnt_reg + 1'b1;
                    m_row_log_prob <= lp_reg;
                    m_total_log_lik <= ll_new_reg;
                    m_total_log_lik_sq <= (sq_reg > {SQ_W{1'b1}} - 63'(psq_reg)) ?
                                          {SQ_W{1'b1}} : sq_reg + 63'(psq_reg);
                    m_scored_count <= (cnt_reg != {CNT_W{1'b1}}) ? cnt_reg + 1'b1 : cnt_reg;
                end
                default: ;
            endcase
        end
    end
endmodule

/* design/log_softmax_perplexity_accumulator.sv */
// Log-sum-exp cross-entropy scorer: each logit transaction (signed Q8.16)
// passes through the accept step, two exponent steps (scale, then table
// interpolation and shift) and the sum update. The last logit of a row then
// goes through the log, clamp and totals steps and emits one result (log-prob,
// saturating totals, row count) into an output register. The next logit is
// accepted while that result waits, unless a second row end arrives first.
// Configuration writes are taken only while idle and no logit is offered.
module log_softmax_perplexity_accumulator (
    input  logic aclk,
    input  logic aresetn,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [lsepa_pkg::LEN_W-1:0] cfg_data,
    input  logic s_valid,
    output logic s_ready,
    input  logic signed [lsepa_pkg::LOGIT_W-1:0] s_logit,
    input  logic [lsepa_pkg::TGT_W-1:0] s_target_token,
    input  logic s_clear_totals,
    output logic m_valid,
    input  logic m_ready,
    output logic signed [lsepa_pkg::LP_W-1:0] m_row_log_prob,
    output logic signed [lsepa_pkg::LL_W-1:0] m_total_log_lik,
    output logic [lsepa_pkg::SQ_W-1:0] m_total_log_lik_sq,
    output logic [lsepa_pkg::CNT_W-1:0] m_scored_count
);
    import lsepa_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // controller sequences one logit at a time
    lsepa_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready,
        .stat, .cmd, .cfg_ready
    );

    lsepa_datapath u_dp (
        .aclk, .aresetn, .cmd, .stat,
        .cfg_we(cfg_valid && cfg_ready), .cfg_data,
        .s_logit, .s_target_token, .s_clear_totals,
        .m_row_log_prob, .m_total_log_lik, .m_total_log_lik_sq, .m_scored_count
    );
endmodule

/* design/lsepa_checker.sv */
module lsepa_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input logic signed [24:0] m_row_log_prob,
    input logic [31:0] m_scored_count
);
    a_mhold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_scored_count))
        else $error("result dropped");
    a_lp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_row_log_prob[24] || m_row_log_prob == 25'sd0)
        else $error("log prob range");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("accepted while busy");
endmodule

bind log_softmax_perplexity_accumulator lsepa_checker u_chk (
    .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready,
    .m_row_log_prob, .m_scored_count
);
